// ===== rtl/core/sci_ub_pkg.sv =====
// Package of shared types, constants and functions for the serial buffer unit.
`default_nettype none

package sci_ub_pkg;

    // Queue geometry.
    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Character timing: bits per character, oversampling and prescaler table.
    localparam int unsigned CHAR_BITS  = 11;
    localparam int unsigned OVERSAMPLE = 16;
    localparam int unsigned PRESCALE [4] = '{1, 3, 4, 13};
    localparam int unsigned TIMER_W    = 19;

    // Field widths.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned TICK_W  = 10;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // Status byte flags.
    localparam logic [BYTE_W-1:0] STAT_HOLD_EMPTY = 8'h80;
    localparam logic [BYTE_W-1:0] STAT_IDLE       = 8'h40;
    localparam logic [BYTE_W-1:0] STAT_RX_DATA    = 8'h20;

    // Operation codes of an input word.
    typedef enum logic [OP_W-1:0] {
        OP_READ_STATUS = 3'd0,
        OP_READ_DATA   = 3'd1,
        OP_WRITE_DATA  = 3'd2,
        OP_LINE_RX     = 3'd3,
        OP_TICK        = 3'd4,
        OP_TAKE_TX     = 3'd5
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_BAUD        = 2'd0,
        REG_RX_IE       = 2'd1,
        REG_TX_EMPTY_IE = 2'd2,
        REG_TX_DONE_IE  = 2'd3
    } reg_idx_t;

    // Length of one character in clock cycles for a given baud setting.
    function automatic logic [TIMER_W-1:0] char_time(input logic [BYTE_W-1:0] baud);
        logic [TIMER_W-1:0] base;
        base = TIMER_W'(CHAR_BITS * OVERSAMPLE * PRESCALE[baud[5:4]]);
        return base << baud[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sci_uart_buffer_unit.sv =====
// Serial port buffer unit: receive and transmit queues, hold register and character timer.
// A word in the input register moves its result into the result register once that is free or being taken.
// Throughput: one word per cycle while results are taken; with a result waiting, a new
// word can still enter, but only if the input register is empty.
// Reset (aresetn low, synchronous): queues empty, timer idle, hold register empty and
// all configuration registers zero. No clearing pass is needed.
`default_nettype none

module sci_uart_buffer_unit
    import sci_ub_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,

    // Input channel.
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [OP_W-1:0]   s_operation,
    input  wire logic [BYTE_W-1:0] s_data_in,
    input  wire logic [TICK_W-1:0] s_tick_cycles,

    // Result channel.
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [BYTE_W-1:0] m_read_data,
    output logic                   m_accepted,
    output logic                   m_irq_request
);

    // Configuration registers.
    logic [BYTE_W-1:0] baud_reg;
    logic              rx_ie_reg;
    logic              tx_empty_ie_reg;
    logic              tx_done_ie_reg;

    // Input register.
    logic              in_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [TICK_W-1:0] cyc_reg;

    // Result register.
    logic              out_valid_reg;
    logic [BYTE_W-1:0] rd_reg,  rd_next;
    logic              acc_reg, acc_next;
    logic              irq_reg, irq_next;

    // Block state.
    logic [BYTE_W-1:0]  rx_store_reg [QUEUE_DEPTH];
    logic [BYTE_W-1:0]  tx_store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   rx_head_reg, rx_head_next;
    logic [PTR_W-1:0]   rx_tail_reg, rx_tail_next;
    logic [FILL_W-1:0]  rx_fill_reg, rx_fill_next;
    logic [PTR_W-1:0]   tx_head_reg, tx_head_next;
    logic [PTR_W-1:0]   tx_tail_reg, tx_tail_next;
    logic [FILL_W-1:0]  tx_fill_reg, tx_fill_next;
    logic [TIMER_W-1:0] left_reg,    left_next;
    logic [BYTE_W-1:0]  hold_reg,    hold_next;
    logic               hold_full_reg, hold_full_next;

    // Step control.
    logic               advance;
    logic               cfg_write;
    logic               rx_push;
    logic               tx_push;
    logic [BYTE_W-1:0]  tx_push_data;
    logic [TIMER_W-1:0] ct;
    logic [TIMER_W-1:0] cyc_ext;
    logic [TIMER_W-1:0] rem;
    logic               rx_full;
    logic               tx_full;
    logic [BYTE_W-1:0]  status;

    // Handshake: the input register moves on when the result register is free or its result is being taken.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid       = out_valid_reg;
    assign m_read_data   = rd_reg;
    assign m_accepted    = acc_reg;
    assign m_irq_request = irq_reg;

    // Configuration port: always ready, written in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_BAUD:        prdata = DATA_W'(baud_reg);
            REG_RX_IE:       prdata = DATA_W'(rx_ie_reg);
            REG_TX_EMPTY_IE: prdata = DATA_W'(tx_empty_ie_reg);
            REG_TX_DONE_IE:  prdata = DATA_W'(tx_done_ie_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baud_reg        <= '0;
            rx_ie_reg       <= 1'b0;
            tx_empty_ie_reg <= 1'b0;
            tx_done_ie_reg  <= 1'b0;
        end else if (cfg_write) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_BAUD:        baud_reg        <= pwdata[BYTE_W-1:0];
                REG_RX_IE:       rx_ie_reg       <= pwdata[0];
                REG_TX_EMPTY_IE: tx_empty_ie_reg <= pwdata[0];
                REG_TX_DONE_IE:  tx_done_ie_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Shared values for the step.
    assign ct      = char_time(baud_reg);
    assign cyc_ext = TIMER_W'(cyc_reg);
    assign rem     = cyc_ext - left_reg;
    assign rx_full = (rx_fill_reg == FILL_W'(QUEUE_DEPTH));
    assign tx_full = (tx_fill_reg == FILL_W'(QUEUE_DEPTH));

    // Step logic: one word against the current state.
    always_comb begin
        rx_head_next   = rx_head_reg;
        rx_tail_next   = rx_tail_reg;
        rx_fill_next   = rx_fill_reg;
        tx_head_next   = tx_head_reg;
        tx_tail_next   = tx_tail_reg;
        tx_fill_next   = tx_fill_reg;
        left_next      = left_reg;
        hold_next      = hold_reg;
        hold_full_next = hold_full_reg;
        rd_next        = '0;
        acc_next       = 1'b0;
        rx_push        = 1'b0;
        tx_push        = 1'b0;
        tx_push_data   = data_reg;

        case (op_t'(op_reg))
            OP_READ_STATUS: begin
                rd_next = (hold_full_reg     ? '0 : STAT_HOLD_EMPTY) |
                          ((left_reg != '0)  ? '0 : STAT_IDLE) |
                          ((rx_fill_reg == '0) ? '0 : STAT_RX_DATA);
            end
            OP_READ_DATA: begin
                if (rx_fill_reg != '0) begin
                    rd_next      = rx_store_reg[rx_head_reg];
                    rx_head_next = (rx_head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : rx_head_reg + PTR_W'(1);
                    rx_fill_next = rx_fill_reg - FILL_W'(1);
                end
            end
            OP_WRITE_DATA: begin
                if (left_reg == '0) begin
                    tx_push = !tx_full;
                end else if (!hold_full_reg) begin
                    hold_next      = data_reg;
                    hold_full_next = 1'b1;
                end
            end
            OP_LINE_RX: begin
                if (!rx_full) begin
                    rx_push      = 1'b1;
                    rx_tail_next = (rx_tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : rx_tail_reg + PTR_W'(1);
                    rx_fill_next = rx_fill_reg + FILL_W'(1);
                    acc_next     = 1'b1;
                end
            end
            OP_TICK: begin
                // At most one held character can start within one tick.
                if (left_reg != '0 && cyc_reg != '0) begin
                    if (cyc_ext < left_reg) begin
                        left_next = left_reg - cyc_ext;
                    end else begin
                        left_next = '0;
                        if (hold_full_reg) begin
                            hold_full_next = 1'b0;
                            tx_push_data   = hold_reg;
                            if (!tx_full) begin
                                tx_push   = 1'b1;
                                left_next = (rem < ct) ? ct - rem : '0;
                            end
                        end
                    end
                end
            end
            OP_TAKE_TX: begin
                if (tx_fill_reg != '0) begin
                    rd_next      = tx_store_reg[tx_head_reg];
                    tx_head_next = (tx_head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : tx_head_reg + PTR_W'(1);
                    tx_fill_next = tx_fill_reg - FILL_W'(1);
                    acc_next     = 1'b1;
                end
            end
            default: ;
        endcase

        // A character start pushes the byte and, from a write, loads the timer.
        if (tx_push) begin
            tx_tail_next = (tx_tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                           '0 : tx_tail_reg + PTR_W'(1);
            tx_fill_next = tx_fill_reg + FILL_W'(1);
            if (op_t'(op_reg) == OP_WRITE_DATA) begin
                left_next = ct;
            end
        end

        // Interrupt request from the state after the step.
        status   = (hold_full_next      ? '0 : STAT_HOLD_EMPTY) |
                   ((left_next != '0)   ? '0 : STAT_IDLE) |
                   ((rx_fill_next == '0) ? '0 : STAT_RX_DATA);
        irq_next = (rx_ie_reg       && ((status & STAT_RX_DATA)    != '0)) ||
                   (tx_empty_ie_reg && ((status & STAT_HOLD_EMPTY) != '0)) ||
                   (tx_done_ie_reg  && ((status & STAT_IDLE)       != '0));
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            data_reg <= s_data_in;
            cyc_reg  <= s_tick_cycles;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_reg  <= rd_next;
            acc_reg <= acc_next;
            irq_reg <= irq_next;
        end
    end

    // Control state, updated once per processed word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            rx_fill_reg   <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_fill_reg   <= '0;
            left_reg      <= '0;
            hold_reg      <= '0;
            hold_full_reg <= 1'b0;
        end else if (advance) begin
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            rx_fill_reg   <= rx_fill_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            tx_fill_reg   <= tx_fill_next;
            left_reg      <= left_next;
            hold_reg      <= hold_next;
            hold_full_reg <= hold_full_next;
        end
    end

    // Queue storage, written at the tail pointers.
    always_ff @(posedge aclk) begin
        if (advance && rx_push) begin
            rx_store_reg[rx_tail_reg] <= data_reg;
        end
        if (advance && tx_push) begin
            tx_store_reg[tx_tail_reg] <= tx_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the serial port buffer unit, with a predictor and random traffic.
module testbench;
    import sci_ub_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 23;
    localparam int PHASE_WORDS    = 64;

    // One input word and one result word.
    typedef struct packed {
        op_t                op;
        logic [BYTE_W-1:0]  data;
        logic [TICK_W-1:0]  ticks;
    } port_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        logic               accepted;
        logic               irq_request;
    } reply_t;

    // A row of the directed table; the reply is only used where fixed is set.
    typedef struct {
        op_t                op;
        logic [BYTE_W-1:0]  data;
        logic [TICK_W-1:0]  ticks;
        bit                 fixed;
        logic [BYTE_W-1:0]  read_data;
        logic               accepted;
        logic               irq_request;
    } script_row_t;

    // Operation mixes for the random phases.
    typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_operation   = '0;
    logic [BYTE_W-1:0] s_data_in     = '0;
    logic [TICK_W-1:0] s_tick_cycles = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_read_data;
    logic              m_accepted;
    logic              m_irq_request;

    sci_uart_buffer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_data_in     (s_data_in),
        .s_tick_cycles (s_tick_cycles),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_accepted    (m_accepted),
        .m_irq_request (m_irq_request)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predicted state of the port and its configuration.
    logic [BYTE_W-1:0]  cfg_baud     = '0;
    logic               cfg_rx_ie    = 1'b0;
    logic               cfg_txe_ie   = 1'b0;
    logic               cfg_txd_ie   = 1'b0;
    logic [BYTE_W-1:0]  rx_bytes [$];
    logic [BYTE_W-1:0]  tx_bytes [$];
    logic [TIMER_W-1:0] char_left    = '0;
    logic [BYTE_W-1:0]  held_byte    = '0;
    logic               held_full    = 1'b0;

    reply_t replies_due [$];
    int     mismatches   = 0;
    int     results_seen = 0;
    int     quiet_cycles = 0;
    int     in_calm      = 0;
    int     out_calm     = 0;
    int     out_stall    = 0;

    // Directed words: empty queues, extremes of the fields, the hold register and its
    // overflow, and ticks that finish a character and carry on into the held one.
    script_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_READ_STATUS, 8'h00, 10'd0,    1'b1, 8'hC0, 1'b0, 1'b0},
        '{OP_READ_DATA,   8'h00, 10'd0,    1'b1, 8'h00, 1'b0, 1'b0},
        '{OP_TAKE_TX,     8'h00, 10'd0,    1'b1, 8'h00, 1'b0, 1'b0},
        '{OP_TICK,        8'h00, 10'd1023, 1'b1, 8'h00, 1'b0, 1'b0},
        '{OP_LINE_RX,     8'hFF, 10'd0,    1'b1, 8'h00, 1'b1, 1'b1},
        '{OP_LINE_RX,     8'h00, 10'd1023, 1'b1, 8'h00, 1'b1, 1'b1},
        '{OP_READ_STATUS, 8'h00, 10'd0,    1'b1, 8'hE0, 1'b0, 1'b1},
        '{OP_READ_DATA,   8'h00, 10'd0,    1'b1, 8'hFF, 1'b0, 1'b1},
        '{OP_READ_DATA,   8'hFF, 10'd0,    1'b1, 8'h00, 1'b0, 1'b0},
        '{OP_WRITE_DATA,  8'hA5, 10'd0,    1'b1, 8'h00, 1'b0, 1'b0},
        '{OP_WRITE_DATA,  8'h5A, 10'd0,    1'b1, 8'h00, 1'b0, 1'b0},
        '{OP_WRITE_DATA,  8'h3C, 10'd0,    1'b1, 8'h00, 1'b0, 1'b0},
        '{OP_READ_STATUS, 8'h00, 10'd0,    1'b1, 8'h00, 1'b0, 1'b0},
        '{OP_TICK,        8'h00, 10'd0,    1'b0, 8'h00, 1'b0, 1'b0},
        '{OP_TICK,        8'h00, 10'd100,  1'b0, 8'h00, 1'b0, 1'b0},
        '{OP_TICK,        8'h00, 10'd1023, 1'b0, 8'h00, 1'b0, 1'b0},
        '{OP_TAKE_TX,     8'h00, 10'd0,    1'b1, 8'hA5, 1'b1, 1'b0},
        '{OP_TAKE_TX,     8'h00, 10'd0,    1'b1, 8'h5A, 1'b1, 1'b0},
        '{OP_TAKE_TX,     8'h00, 10'd0,    1'b1, 8'h00, 1'b0, 1'b0},
        '{OP_WRITE_DATA,  8'h81, 10'd0,    1'b0, 8'h00, 1'b0, 1'b0},
        '{OP_TICK,        8'h00, 10'd176,  1'b0, 8'h00, 1'b0, 1'b0},
        '{OP_READ_STATUS, 8'h00, 10'd0,    1'b1, 8'hC0, 1'b0, 1'b0},
        '{OP_TAKE_TX,     8'h00, 10'd0,    1'b1, 8'h81, 1'b1, 1'b0}
    };

    // Character length in clock cycles for the current baud setting.
    function automatic logic [TIMER_W-1:0] char_length();
        int unsigned pre;
        case (cfg_baud[5:4])
            2'd0: pre = 1;
            2'd1: pre = 3;
            2'd2: pre = 4;
            default: pre = 13;
        endcase
        return TIMER_W'((CHAR_BITS * OVERSAMPLE * pre) << cfg_baud[2:0]);
    endfunction

    function automatic logic [BYTE_W-1:0] status_now();
        logic [BYTE_W-1:0] s;
        s = '0;
        if (!held_full) s |= STAT_HOLD_EMPTY;
        if (char_left == 0) s |= STAT_IDLE;
        if (rx_bytes.size() != 0) s |= STAT_RX_DATA;
        return s;
    endfunction

    // A byte starts only if the transmit queue has room; otherwise the line stays idle.
    function automatic void start_char(input logic [BYTE_W-1:0] b);
        if (tx_bytes.size() < QUEUE_DEPTH) begin
            tx_bytes.push_back(b);
            char_left = char_length();
        end
    endfunction

    // Count the timer down; a finished character hands the rest of the tick to the held byte.
    function automatic void spend_ticks(input int unsigned n);
        while (char_left != 0 && n != 0) begin
            if (n < 32'(char_left)) begin
                char_left = char_left - TIMER_W'(n);
                n = 0;
            end else begin
                n = n - 32'(char_left);
                char_left = '0;
                if (held_full) begin
                    held_full = 1'b0;
                    start_char(held_byte);
                end
            end
        end
    endfunction

    // Apply one word to the predicted port and return the reply it gives.
    function automatic reply_t port_step(input port_word_t w);
        reply_t            r;
        logic [BYTE_W-1:0] s;
        r = '0;
        case (w.op)
            OP_READ_STATUS: r.read_data = status_now();
            OP_READ_DATA: begin
                if (rx_bytes.size() != 0) r.read_data = rx_bytes.pop_front();
            end
            OP_WRITE_DATA: begin
                if (char_left == 0) begin
                    start_char(w.data);
                end else if (!held_full) begin
                    held_byte = w.data;
                    held_full = 1'b1;
                end
            end
            OP_LINE_RX: begin
                if (rx_bytes.size() < QUEUE_DEPTH) begin
                    rx_bytes.push_back(w.data);
                    r.accepted = 1'b1;
                end
            end
            OP_TICK: spend_ticks(32'(w.ticks));
            OP_TAKE_TX: begin
                if (tx_bytes.size() != 0) begin
                    r.read_data = tx_bytes.pop_front();
                    r.accepted  = 1'b1;
                end
            end
            default: ;
        endcase
        s = status_now();
        r.irq_request = (cfg_rx_ie && (s & STAT_RX_DATA) != 0) ||
                        (cfg_txe_ie && (s & STAT_HOLD_EMPTY) != 0) ||
                        (cfg_txd_ie && (s & STAT_IDLE) != 0);
        return r;
    endfunction

    // Gap length: mostly none or short, a few long, and now and then a calm stretch.
    function automatic int pick_gap(inout int calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic port_word_t random_word(input mix_t mix);
        int unsigned weight [6];
        int unsigned r;
        int unsigned k;
        port_word_t  w;
        case (mix)
            MIX_FILL:  weight = '{5, 3, 30, 40, 22, 0};
            MIX_DRAIN: weight = '{10, 35, 5, 5, 15, 30};
            default:   weight = '{10, 18, 20, 18, 22, 12};
        endcase
        r = $urandom_range(0, 99);
        k = 0;
        while (k < 5 && r >= weight[k]) begin
            r -= weight[k];
            k++;
        end
        w.op   = op_t'(k);
        w.data = BYTE_W'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r < 7) w.ticks = TICK_W'($urandom_range(0, 1023));
        else if (r < 9) w.ticks = TICK_W'($urandom_range(0, 31));
        else w.ticks = '1;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
        mismatches++;
    endtask

    // Register write over the configuration port: setup cycle, then access cycle.
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BAUD:        cfg_baud   = value[BYTE_W-1:0];
            REG_RX_IE:       cfg_rx_ie  = value[0];
            REG_TX_EMPTY_IE: cfg_txe_ie = value[0];
            REG_TX_DONE_IE:  cfg_txd_ie = value[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] baud, input bit rx_ie,
                              input bit txe_ie, input bit txd_ie);
        write_reg(REG_BAUD, DATA_W'(baud));
        write_reg(REG_RX_IE, DATA_W'(rx_ie));
        write_reg(REG_TX_EMPTY_IE, DATA_W'(txe_ie));
        write_reg(REG_TX_DONE_IE, DATA_W'(txd_ie));
    endtask

    // Offer one word, wait for it to be taken and file the reply it should give.
    task automatic send_word(input port_word_t w, input bit fixed, input reply_t want);
        int     gap;
        reply_t predicted;
        gap = pick_gap(in_calm);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= w.op;
        s_data_in     <= w.data;
        s_tick_cycles <= w.ticks;
        do @(posedge aclk); while (!s_ready);
        predicted = port_step(w);
        replies_due.push_back(fixed ? want : predicted);
    endtask

    task automatic wait_drained();
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input mix_t mix, input int words);
        for (int i = 0; i < words; i++) send_word(random_word(mix), 1'b0, '0);
        s_valid <= 1'b0;
        wait_drained();
    endtask

    // Result checking and receiver stalls.
    always @(posedge aclk) begin : result_check
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected result, read_data", 32'(m_read_data), 0);
            end else begin
                want = replies_due.pop_front();
                if (m_read_data !== want.read_data)
                    report_mismatch("read_data", 32'(m_read_data), 32'(want.read_data));
                if (m_accepted !== want.accepted)
                    report_mismatch("accepted", 32'(m_accepted), 32'(want.accepted));
                if (m_irq_request !== want.irq_request)
                    report_mismatch("irq_request", 32'(m_irq_request),
                                    32'(want.irq_request));
            end
        end
        if (out_stall != 0) begin
            m_ready <= 1'b0;
            out_stall--;
        end else begin
            m_ready <= 1'b1;
            out_stall = pick_gap(out_calm);
        end
    end

    // Watchdog on cycles in which no word moves on either channel and no configuration access is under way.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] baud;
        port_word_t        w;
        reply_t            r;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table at the shortest character time, receive interrupt only.
        set_config(8'h00, 1'b1, 1'b0, 1'b0);
        foreach (directed_rows[i]) begin
            w.op    = directed_rows[i].op;
            w.data  = directed_rows[i].data;
            w.ticks = directed_rows[i].ticks;
            r.read_data   = directed_rows[i].read_data;
            r.accepted    = directed_rows[i].accepted;
            r.irq_request = directed_rows[i].irq_request;
            send_word(w, directed_rows[i].fixed, r);
        end
        s_valid <= 1'b0;
        wait_drained();

        // Random phases; the queues carry over so the fill phases reach both full cases.
        baud = BYTE_W'($urandom_range(0, 255));
        baud[2:0] = 3'($urandom_range(0, 2));
        set_config(baud, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        run_phase(MIX_EVEN, PHASE_WORDS);

        set_config(8'h00, 1'b1, 1'b1, 1'b1);
        run_phase(MIX_FILL, PHASE_WORDS);

        set_config(8'hC1, 1'b0, 1'b1, 1'b0);
        run_phase(MIX_FILL, PHASE_WORDS);

        baud = BYTE_W'($urandom_range(0, 255));
        baud[2:0] = 3'($urandom_range(0, 1));
        set_config(baud, 1'b0, 1'b0, 1'b1);
        run_phase(MIX_DRAIN, PHASE_WORDS);

        baud = BYTE_W'($urandom_range(0, 255));
        baud[2:0] = 3'($urandom_range(0, 2));
        set_config(baud, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        run_phase(MIX_EVEN, PHASE_WORDS);

        // Longest character time last, so a slow character does not stall later phases.
        set_config(8'hFF, 1'b1, 1'b1, 1'b1);
        run_phase(MIX_EVEN, PHASE_WORDS);

        repeat (3) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
